// ===== rtl/pcx_rle_palette_decoder_defines.svh =====
// assertion macros for the decoder rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef PCX_RLE_PALETTE_DECODER_DEFINES_SVH
`define PCX_RLE_PALETTE_DECODER_DEFINES_SVH

// same-cycle implication
`define PCX_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcx_pkg.sv =====
// types and constants of the pcx rle palette decoder
// no dependencies
package pcx_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [1:0] RUN_MARK   = 2'b11;
    localparam int         CFG_IDX_W  = 2;
    localparam int         CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_LINE_BYTES   = 2'd2
    } t_cfg_index;

    typedef enum logic {
        OP_PALETTE = 1'b0,
        OP_RUN     = 1'b1
    } t_op_kind;

    // value byte of a run travels in idx
    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  idx;
        logic [23:0] rgb;
        logic [5:0]  count;
    } t_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_back_state;

endpackage

// ===== rtl/pcx_front.sv =====
// front end: accepts input transactions and turns them into queue operations
// depends on pcx_pkg
module pcx_front
    import pcx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_cmd,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_palette_rgb,
    input  logic [7:0]  i_data_byte,
    output logic        o_enq,
    output t_op         o_op
);

    logic       r_run_pending, n_run_pending;
    logic [5:0] r_run_length, n_run_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pending <= 1'b0;
            r_run_length  <= '0;
        end else begin
            r_run_pending <= n_run_pending;
            r_run_length  <= n_run_length;
        end
    end

    always_comb begin
        n_run_pending = r_run_pending;
        n_run_length  = r_run_length;
        o_enq         = 1'b0;
        o_op.kind     = OP_RUN;
        o_op.idx      = i_data_byte;
        o_op.rgb      = i_palette_rgb;
        o_op.count    = 6'd1;
        if (i_accept) begin
            if (i_cmd == 1'b0) begin
                o_enq     = 1'b1;
                o_op.kind = OP_PALETTE;
                o_op.idx  = i_palette_index;
            end else if (r_run_pending) begin
                o_enq         = 1'b1;
                o_op.count    = r_run_length;
                n_run_pending = 1'b0;
            end else if (i_data_byte[7:6] == RUN_MARK) begin
                n_run_pending = 1'b1;
                n_run_length  = i_data_byte[5:0];
            end else begin
                o_enq = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/pcx_queue.sv =====
// short fifo of operations between front and back
// depends on pcx_pkg
module pcx_queue
    import pcx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_enq,
    input  t_op       i_op,
    input  logic      i_deq,
    output t_op       o_op,
    output t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op            r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_enq, do_deq;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign do_enq = i_enq && !o_status.full;
    assign do_deq = i_deq && !o_status.empty;
    assign o_op   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_enq) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_deq) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_enq && !do_deq) begin
            n_count = r_count + 1'b1;
        end else if (do_deq && !do_enq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== rtl/pcx_back.sv =====
// back end: palette memory, run expansion sequencer, config registers, output register
// depends on pcx_pkg and pcx_rle_palette_decoder_defines.svh
`include "pcx_rle_palette_decoder_defines.svh"

module pcx_back
    import pcx_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_op                   i_op,
    input  t_q_status             i_q_status,
    output logic                  o_deq,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [15:0]           o_pixel_x,
    output logic [15:0]           o_pixel_y,
    output logic                  o_last_of_run,
    output logic                  o_last_in_row,
    output logic                  o_last_of_image
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [23:0]  r_colour_table [PALETTE_ENTRIES];
    logic [23:0]  r_rgb;
    logic         mem_wr, mem_rd;

    logic [16:0]  r_width;
    logic [16:0]  r_height;
    logic [15:0]  r_line_bytes;

    t_back_state  r_state, n_state;
    logic [5:0]   r_remain, n_remain;
    logic [15:0]  r_pos, n_pos;
    logic [16:0]  r_row, n_row;
    logic         r_finished, n_finished;

    logic         r_o_valid, n_o_valid;
    logic [23:0]  r_o_rgb, n_o_rgb;
    logic [15:0]  r_o_x, n_o_x;
    logic [15:0]  r_o_y, n_o_y;
    logic         r_o_lrun, n_o_lrun;
    logic         r_o_lrow, n_o_lrow;
    logic         r_o_limg, n_o_limg;

    logic [15:0]  lb_eff;
    logic [16:0]  ht_eff;
    logic [16:0]  pos_inc;
    logic [17:0]  row_inc;
    logic         emit, slot_free, wrap, eol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= 17'd1;
            r_height     <= 17'd1;
            r_line_bytes <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width      <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height     <= i_cfg_data;
                CFG_LINE_BYTES:   r_line_bytes <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign lb_eff    = (r_line_bytes == '0) ? 16'd1 : r_line_bytes;
    assign ht_eff    = (r_height == '0) ? 17'd1 : r_height;
    assign pos_inc   = {1'b0, r_pos} + 17'd1;
    assign row_inc   = {1'b0, r_row} + 18'd1;
    assign emit      = ({1'b0, r_pos} < r_width);
    assign slot_free = !r_o_valid || i_pop;
    assign wrap      = (pos_inc >= {1'b0, lb_eff});
    assign eol       = (pos_inc == r_width);

    always_comb begin
        n_state    = r_state;
        n_remain   = r_remain;
        n_pos      = r_pos;
        n_row      = r_row;
        n_finished = r_finished;
        n_o_valid  = r_o_valid && !i_pop;
        n_o_rgb    = r_o_rgb;
        n_o_x      = r_o_x;
        n_o_y      = r_o_y;
        n_o_lrun   = r_o_lrun;
        n_o_lrow   = r_o_lrow;
        n_o_limg   = r_o_limg;
        o_deq      = 1'b0;
        mem_wr     = 1'b0;
        mem_rd     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_deq = 1'b1;
                    if (i_op.kind == OP_PALETTE) begin
                        mem_wr = 1'b1;
                    end else if (!r_finished && i_op.count != '0) begin
                        mem_rd   = 1'b1;
                        n_remain = i_op.count;
                        n_state  = BK_RUN;
                    end
                end
            end
            BK_RUN: begin
                if (!emit || slot_free) begin
                    if (emit) begin
                        n_o_valid = 1'b1;
                        n_o_rgb   = r_rgb;
                        n_o_x     = r_pos;
                        n_o_y     = r_row[15:0];
                        n_o_lrun  = (r_remain == 6'd1) || (pos_inc >= r_width) || wrap;
                        n_o_lrow  = eol;
                        n_o_limg  = eol && (row_inc == {1'b0, r_height});
                    end
                    n_remain = r_remain - 6'd1;
                    if (wrap) begin
                        n_pos      = '0;
                        n_row      = row_inc[16:0];
                        n_finished = r_finished || (row_inc[16:0] >= ht_eff);
                        n_state    = BK_IDLE;
                    end else begin
                        n_pos = pos_inc[15:0];
                        if (r_remain == 6'd1) begin
                            n_state = BK_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_remain   <= '0;
            r_pos      <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_remain   <= n_remain;
            r_pos      <= n_pos;
            r_row      <= n_row;
            r_finished <= n_finished;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_rgb  <= n_o_rgb;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_o_lrun <= n_o_lrun;
        r_o_lrow <= n_o_lrow;
        r_o_limg <= n_o_limg;
    end

    // palette memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_colour_table[i_op.idx[AW-1:0]] <= i_op.rgb;
        end
        if (mem_rd) begin
            r_rgb <= r_colour_table[i_op.idx[AW-1:0]];
        end
    end

    assign o_empty         = !r_o_valid;
    assign o_red           = r_o_rgb[23:16];
    assign o_green         = r_o_rgb[15:8];
    assign o_blue          = r_o_rgb[7:0];
    assign o_pixel_x       = r_o_x;
    assign o_pixel_y       = r_o_y;
    assign o_last_of_run   = r_o_lrun;
    assign o_last_in_row   = r_o_lrow;
    assign o_last_of_image = r_o_limg;

    `PCX_ASSERT_IMPLY(a_run_has_count, r_state == BK_RUN, r_remain != 6'd0, "run with no count left")
    `PCX_ASSERT_NEXT(a_finished_sticky, r_finished, r_finished, "image end flag cleared")
    `PCX_ASSERT_IMPLY(a_deq_only_idle, o_deq, r_state == BK_IDLE, "queue read while expanding")
    `PCX_ASSERT_NEXT(a_no_pixel_after_end, r_finished && !r_o_valid && r_state == BK_IDLE, !r_o_valid, "pixel after image end")

endmodule

// ===== rtl/pcx_rle_palette_decoder.sv =====
// pcx rle palette decoder: an 8-bit single-plane run-length byte stream in, rgb pixels out.
// A palette write is one back-end queue pop, a run header byte is absorbed by the front end
// alone, and a literal or a run of n is popped in the idle state, which also reads the palette
// memory; the expansion sequencer then walks up to n line positions at one per cycle, padding
// included, stalling on a visible pixel while an unpopped one fills the output register, so
// pixels leave at one per cycle with pop held. A four-entry operation queue parts the input
// from the sequencer; full rises only when it fills. Palette writes go through the queue in
// order with data bytes. Palette memory has no reset or clearing pass; config is always ready.
module pcx_rle_palette_decoder
    import pcx_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_cmd,
    input  logic [7:0]            i_palette_index,
    input  logic [23:0]           i_palette_rgb,
    input  logic [7:0]            i_data_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [15:0]           o_pixel_x,
    output logic [15:0]           o_pixel_y,
    output logic                  o_last_of_run,
    output logic                  o_last_in_row,
    output logic                  o_last_of_image,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      enq, deq;
    t_op       enq_op, deq_op;
    t_q_status q_status;

    assign full = q_status.full;

    pcx_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (push && !q_status.full),
        .i_cmd           (i_cmd),
        .i_palette_index (i_palette_index),
        .i_palette_rgb   (i_palette_rgb),
        .i_data_byte     (i_data_byte),
        .o_enq           (enq),
        .o_op            (enq_op)
    );

    pcx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enq    (enq),
        .i_op     (enq_op),
        .i_deq    (deq),
        .o_op     (deq_op),
        .o_status (q_status)
    );

    pcx_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (deq_op),
        .i_q_status      (q_status),
        .o_deq           (deq),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_run   (o_last_of_run),
        .o_last_in_row   (o_last_in_row),
        .o_last_of_image (o_last_of_image)
    );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for pcx_rle_palette_decoder: queued byte stream in, rgb pixels out
// predicts pixels on accepted transactions and checks each popped pixel in order
// depends on rtl/pcx_pkg.sv and rtl/pcx_rle_palette_decoder.sv
`timescale 1ns / 1ps

module tb_top
    import pcx_pkg::*;
();

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 400;

    typedef struct {
        t_op_kind    cmd;
        logic [7:0]  pal_idx;
        logic [23:0] pal_rgb;
        logic [7:0]  data;
    } t_stream_entry;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] x;
        logic [15:0] y;
        logic        last_of_run;
        logic        last_in_row;
        logic        last_of_image;
    } t_pixel;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  push            = 1'b0;
    logic                  full;
    logic                  i_cmd           = 1'b0;
    logic [7:0]            i_palette_index = '0;
    logic [23:0]           i_palette_rgb   = '0;
    logic [7:0]            i_data_byte     = '0;
    logic                  empty;
    logic                  pop             = 1'b0;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic [15:0]           o_pixel_x;
    logic [15:0]           o_pixel_y;
    logic                  o_last_of_run;
    logic                  o_last_in_row;
    logic                  o_last_of_image;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    t_stream_entry pending_entries[$];
    t_stream_entry cur_entry;
    t_pixel        expected_pixels[$];
    bit            colour_set[256];

    // decoder state mirror
    logic [23:0]   colour_mem[256];
    bit            run_wait     = 1'b0;
    int unsigned   run_len      = 0;
    int unsigned   line_pos     = 0;
    int unsigned   row_cnt      = 0;
    bit            img_done     = 1'b0;
    int unsigned   img_cols     = 1;
    int unsigned   img_rows     = 1;
    int unsigned   line_len     = 1;

    int            send_idle    = 0;
    int            recv_idle    = 0;
    int            pixel_errors = 0;
    int            quiet_cycles = 0;

    pcx_rle_palette_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_palette_index (i_palette_index),
        .i_palette_rgb   (i_palette_rgb),
        .i_data_byte     (i_data_byte),
        .empty           (empty),
        .pop             (pop),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_run   (o_last_of_run),
        .o_last_in_row   (o_last_in_row),
        .o_last_of_image (o_last_of_image),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic decode_entry(t_stream_entry e);
        int unsigned cnt;
        int unsigned lb;
        int unsigned ht;
        int unsigned j;
        logic [23:0] rgb;
        t_pixel      px;
        t_pixel      held;
        bit          have_held;
        have_held = 1'b0;
        if (e.cmd == OP_PALETTE) begin
            colour_mem[e.pal_idx] = e.pal_rgb;
            return;
        end
        if (img_done)
            return;
        if (run_wait) begin
            run_wait = 1'b0;
            cnt = run_len;
        end else if (e.data[7:6] == RUN_MARK) begin
            run_wait = 1'b1;
            run_len = e.data[5:0];
            return;
        end else begin
            cnt = 1;
        end
        lb = (line_len == 0) ? 1 : line_len;
        ht = (img_rows == 0) ? 1 : img_rows;
        rgb = colour_mem[e.data];
        for (j = 0; j < cnt; j++) begin
            if (line_pos < img_cols) begin
                if (have_held)
                    expected_pixels.push_back(held);
                px.red = rgb[23:16];
                px.green = rgb[15:8];
                px.blue = rgb[7:0];
                px.x = line_pos[15:0];
                px.y = row_cnt[15:0];
                px.last_of_run = 1'b0;
                px.last_in_row = (line_pos + 1 == img_cols);
                px.last_of_image = px.last_in_row && (row_cnt + 1 == img_rows);
                held = px;
                have_held = 1'b1;
            end
            line_pos++;
            if (line_pos >= lb) begin
                line_pos = 0;
                row_cnt = (row_cnt + 1) & 32'h1FFFF;
                if (row_cnt >= ht)
                    img_done = 1'b1;
                break;
            end
        end
        if (have_held) begin
            held.last_of_run = 1'b1;
            expected_pixels.push_back(held);
        end
    endtask

    function automatic string fmt_pixel(t_pixel p);
        return $sformatf("rgb=%02h%02h%02h x=%0d y=%0d run=%b row=%b img=%b",
                         p.red, p.green, p.blue, p.x, p.y,
                         p.last_of_run, p.last_in_row, p.last_of_image);
    endfunction

    task automatic check_pixel();
        t_pixel got;
        t_pixel want;
        got = {o_red, o_green, o_blue, o_pixel_x, o_pixel_y,
               o_last_of_run, o_last_in_row, o_last_of_image};
        if (expected_pixels.size() == 0) begin
            pixel_errors++;
            if (pixel_errors <= 10)
                $display("unexpected pixel: %s", fmt_pixel(got));
        end else begin
            want = expected_pixels.pop_front();
            if (got != want) begin
                pixel_errors++;
                if (pixel_errors <= 10)
                    $display("pixel mismatch: expected %s, got %s",
                             fmt_pixel(want), fmt_pixel(got));
            end
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                decode_entry(cur_entry);
            if (!push || !full) begin
                if (pending_entries.size() != 0 && $urandom_range(99) >= send_idle) begin
                    cur_entry = pending_entries.pop_front();
                    push <= 1'b1;
                    i_cmd <= cur_entry.cmd;
                    i_palette_index <= cur_entry.pal_idx;
                    i_palette_rgb <= cur_entry.pal_rgb;
                    i_data_byte <= cur_entry.data;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_pixel();
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** pcx_rle_palette_decoder: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_reg(t_cfg_index idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                img_cols = val & 32'h1FFFF;
            end
            CFG_IMAGE_HEIGHT: begin
                img_rows = val & 32'h1FFFF;
            end
            default: begin
                line_len = val & 32'hFFFF;
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_palette(logic [7:0] idx, logic [23:0] rgb);
        t_stream_entry e;
        e.cmd = OP_PALETTE;
        e.pal_idx = idx;
        e.pal_rgb = rgb;
        e.data = 8'($urandom);
        colour_set[idx] = 1'b1;
        pending_entries.push_back(e);
    endtask

    task automatic queue_byte(logic [7:0] b);
        t_stream_entry e;
        e.cmd = OP_RUN;
        e.pal_idx = 8'($urandom);
        e.pal_rgb = 24'($urandom);
        e.data = b;
        pending_entries.push_back(e);
    endtask

    // only colours that were loaded, so no pixel reads an empty palette slot
    function automatic logic [7:0] pick_colour(bit literal_only);
        logic [7:0] v;
        do v = 8'($urandom_range(literal_only ? 191 : 255)); while (!colour_set[v]);
        return v;
    endfunction

    task automatic queue_random(int n);
        int made;
        int pick;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                queue_palette(8'($urandom), 24'($urandom));
                made += 1;
            end else if (pick < 50) begin
                queue_byte(pick_colour(1'b1));
                made += 1;
            end else if (pick < 92) begin
                queue_byte({RUN_MARK, 6'($urandom_range(63))});
                queue_byte(pick_colour(1'b0));
                made += 2;
            end else begin
                // palette load between run header and value
                queue_byte({RUN_MARK, 6'($urandom_range(63))});
                queue_palette(8'($urandom), 24'($urandom));
                queue_byte(pick_colour(1'b0));
                made += 3;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_entries.size() != 0 || push || expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic set_idle(int s, int r);
        @(negedge i_clk);
        send_idle = s;
        recv_idle = r;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_reg(CFG_IMAGE_WIDTH, 4);
        set_reg(CFG_IMAGE_HEIGHT, 65536);
        set_reg(CFG_LINE_BYTES, 6);
        set_idle(33, 64);
        queue_palette(8'h00, 24'h000000);
        queue_palette(8'hFF, 24'hFFFFFF);
        queue_palette(8'hAA, 24'h55AA55);
        queue_palette(8'h55, 24'hA5C3F0);
        queue_palette(8'hC0, 24'h123456);
        queue_byte(8'h00);
        queue_byte(8'hAA);
        queue_byte({RUN_MARK, 6'd3});
        queue_byte(8'hFF);
        queue_byte({RUN_MARK, 6'd0});
        queue_byte(8'h55);
        queue_byte({RUN_MARK, 6'd63});
        queue_palette(8'h01, 24'h0F0F0F);
        queue_byte(8'h01);
        queue_byte({RUN_MARK, 6'd8});
        queue_byte(8'hC0);
        queue_byte(8'h55);
        wait_idle();

        set_reg(CFG_IMAGE_WIDTH, 70);
        set_reg(CFG_LINE_BYTES, 80);
        set_idle(33, 64);
        queue_random(30);
        wait_idle();

        // width beyond the line, then zero width and zero line length
        set_reg(CFG_IMAGE_WIDTH, 65536);
        set_reg(CFG_LINE_BYTES, 65535);
        set_idle(64, 33);
        queue_random(25);
        wait_idle();

        set_reg(CFG_IMAGE_WIDTH, 0);
        set_reg(CFG_LINE_BYTES, 0);
        set_idle(64, 33);
        queue_random(10);
        wait_idle();

        set_reg(CFG_IMAGE_WIDTH, 1);
        set_reg(CFG_LINE_BYTES, 1);
        set_idle(0, 0);
        queue_random(15);
        wait_idle();

        set_reg(CFG_IMAGE_WIDTH, 20);
        set_reg(CFG_LINE_BYTES, 20);
        set_idle(0, 0);
        queue_random(28);
        wait_idle();

        // finish the image two rows from here, then keep feeding bytes
        set_reg(CFG_IMAGE_WIDTH, 8);
        set_reg(CFG_LINE_BYTES, 10);
        set_reg(CFG_IMAGE_HEIGHT, row_cnt + 2);
        set_idle(0, 0);
        queue_random(30);
        wait_idle();

        set_reg(CFG_IMAGE_HEIGHT, 0);
        set_idle(0, 0);
        queue_random(5);
        wait_idle();

        if (pixel_errors == 0)
            $display("** pcx_rle_palette_decoder: PASSED **");
        else
            $display("** pcx_rle_palette_decoder: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pcx_pkg.sv
rtl/pcx_front.sv
rtl/pcx_queue.sv
rtl/pcx_back.sv
rtl/pcx_rle_palette_decoder.sv
tb/tb_top.sv
